@@ sv/bmp24_pkg.sv @@
// shared types and constants for the 24-bit bmp stream decoder
// used by bmp24_stream_decoder and its checker bmp24_chk; no dependencies
package bmp24_pkg;

    // decoder phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_PIXELS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // result kind carried on the master tuser
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_BAD_SIG   = 2'd1,
        KIND_TOO_LARGE = 2'd2
    } t_kind;

    localparam int COORD_W = 12;

    // fixed header layout: file header plus info header
    localparam int FILE_HDR_BYTES = 14;
    localparam int INFO_HDR_BYTES = 40;
    localparam int HEADER_BYTES = FILE_HDR_BYTES + INFO_HDR_BYTES;

    localparam logic [5:0] HDR_SIG0   = 6'd0;
    localparam logic [5:0] HDR_SIG1   = 6'd1;
    localparam logic [5:0] HDR_WIDTH  = 6'd18;
    localparam logic [5:0] HDR_HEIGHT = 6'd22;
    localparam logic [5:0] HDR_LAST   = 6'(HEADER_BYTES - 1);

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    // one result beat
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
    } t_pix_data;

    typedef struct packed {
        t_kind     kind;
        logic      last;
        t_pix_data data;
    } t_result;

endpackage

@@ sv/bmp24_stream_decoder.sv @@
// top level of the 24-bit bmp stream decoder: header parse, pixel assembly,
// two-entry output buffer; depends on bmp24_pkg
//
//  channel | dir | tdata                                  | tuser       | tlast
//  s_axis  | in  | [7:0] file byte                        | file start  | -
//  m_axis  | out | red, green, blue, column[11:0], row    | kind [1:0]  | last pixel
//
// one byte per cycle while s_axis_tready is high; each result beat is registered;
// the decode is one pass of logic from the state registers to the output buffer.
// synchronous active-low reset returns to idle, waiting for a start beat.
// the output buffer holds two results, so s_axis_tready drops only when both
// entries are full; tready is a register output with no path from m_axis_tready.
module bmp24_stream_decoder #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] file_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [35:24] column, [47:36] row
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_pixel
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // decoder state
    bmp24_pkg::t_phase r_phase, n_phase, c_phase;
    logic [5:0]        r_hc, n_hc, c_hc;
    logic [31:0]       r_width, n_width, c_width;
    logic [31:0]       r_height, n_height, c_height;
    logic [DIM_W-1:0]  r_col, n_col, c_col;
    logic [DIM_W-1:0]  r_row, n_row, c_row;
    logic [1:0]        r_bip, n_bip, c_bip;
    logic [15:0]       r_held, n_held, c_held;
    logic [1:0]        r_pad, n_pad, c_pad;
    logic [7:0]        r_sig, n_sig, c_sig;

    // output buffer
    logic                r_out_valid, r_skid_valid;
    bmp24_pkg::t_result  r_out, r_skid;

    bmp24_pkg::t_result  res;
    logic                res_valid;
    logic                accept, push, pop;
    logic [1:0]          lane;
    logic [DIM_W-1:0]    col_inc, row_inc, w_lo, h_lo;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign push   = accept && res_valid;
    assign pop    = r_out_valid && m_axis_tready;

    assign w_lo    = r_width[DIM_W-1:0];
    assign h_lo    = r_height[DIM_W-1:0];
    assign col_inc = c_col + 1'b1;
    assign row_inc = c_row + 1'b1;

    // per-byte decode
    always_comb begin
        c_phase  = r_phase;
        c_hc     = r_hc;
        c_width  = r_width;
        c_height = r_height;
        c_col    = r_col;
        c_row    = r_row;
        c_bip    = r_bip;
        c_held   = r_held;
        c_pad    = r_pad;
        c_sig    = r_sig;
        lane     = '0;
        // a start beat restarts the file with this byte as header byte 0
        if (s_axis_tuser) begin
            c_phase  = bmp24_pkg::PH_HEADER;
            c_hc     = '0;
            c_width  = '0;
            c_height = '0;
            c_col    = '0;
            c_row    = '0;
            c_bip    = '0;
            c_held   = '0;
            c_pad    = '0;
            c_sig    = '0;
        end

        n_phase   = c_phase;
        n_hc      = c_hc;
        n_width   = c_width;
        n_height  = c_height;
        n_col     = c_col;
        n_row     = c_row;
        n_bip     = c_bip;
        n_held    = c_held;
        n_pad     = c_pad;
        n_sig     = c_sig;
        res       = '0;
        res_valid = 1'b0;

        unique case (c_phase)
            bmp24_pkg::PH_HEADER: begin
                n_hc = c_hc + 1'b1;
                if (c_hc == bmp24_pkg::HDR_SIG0) begin
                    n_sig = s_axis_tdata;
                end else if (c_hc == bmp24_pkg::HDR_SIG1) begin
                    if (c_sig != bmp24_pkg::SIG_B || s_axis_tdata != bmp24_pkg::SIG_M) begin
                        res_valid = 1'b1;
                        res.kind  = bmp24_pkg::KIND_BAD_SIG;
                        n_phase   = bmp24_pkg::PH_DONE;
                    end
                end else if (c_hc >= bmp24_pkg::HDR_WIDTH && c_hc < bmp24_pkg::HDR_HEIGHT) begin
                    lane = 2'(c_hc - bmp24_pkg::HDR_WIDTH);
                    n_width[{lane, 3'b000} +: 8] = s_axis_tdata;
                end else if (c_hc >= bmp24_pkg::HDR_HEIGHT
                             && c_hc < bmp24_pkg::HDR_HEIGHT + 6'd4) begin
                    lane = 2'(c_hc - bmp24_pkg::HDR_HEIGHT);
                    n_height[{lane, 3'b000} +: 8] = s_axis_tdata;
                end
                // end of header: size check
                if (c_hc == bmp24_pkg::HDR_LAST) begin
                    if (c_width > 32'(MAX_DIM) || c_height > 32'(MAX_DIM)) begin
                        res_valid = 1'b1;
                        res.kind  = bmp24_pkg::KIND_TOO_LARGE;
                        n_phase   = bmp24_pkg::PH_DONE;
                    end else if (c_width == '0 || c_height == '0) begin
                        n_phase = bmp24_pkg::PH_DONE;
                    end else begin
                        n_phase = bmp24_pkg::PH_PIXELS;
                    end
                end
            end
            bmp24_pkg::PH_PIXELS: begin
                if (c_pad != '0) begin
                    n_pad = c_pad - 1'b1;
                end else begin
                    unique case (c_bip)
                        2'd0: begin
                            n_held = {8'h00, s_axis_tdata};
                            n_bip  = 2'd1;
                        end
                        2'd1: begin
                            n_held = {s_axis_tdata, c_held[7:0]};
                            n_bip  = 2'd2;
                        end
                        default: begin
                            n_bip            = 2'd0;
                            res_valid        = 1'b1;
                            res.kind         = bmp24_pkg::KIND_PIXEL;
                            res.data.red     = s_axis_tdata;
                            res.data.green   = c_held[15:8];
                            res.data.blue    = c_held[7:0];
                            res.data.column  = bmp24_pkg::COORD_W'(c_col);
                            res.data.row     = bmp24_pkg::COORD_W'(c_row);
                            res.last         = (col_inc == w_lo) && (row_inc == h_lo);
                            // row wrap
                            if (col_inc >= w_lo) begin
                                n_col = '0;
                                n_row = row_inc;
                                n_pad = c_width[1:0];
                            end else begin
                                n_col = col_inc;
                            end
                            if (res.last) begin
                                n_phase = bmp24_pkg::PH_DONE;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bmp24_pkg::PH_IDLE;
            r_hc     <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_bip    <= '0;
            r_held   <= '0;
            r_pad    <= '0;
            r_sig    <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_hc     <= n_hc;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_bip    <= n_bip;
            r_held   <= n_held;
            r_pad    <= n_pad;
            r_sig    <= n_sig;
        end
    end

    // two-entry output buffer: main register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= res;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

@@ sv/bmp24_chk.sv @@
// port-level checker for bmp24_stream_decoder, attached with bind
// depends on bmp24_pkg
module bmp24_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // error beats carry an all-zero payload and no last flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != bmp24_pkg::KIND_PIXEL |->
            m_axis_tdata == '0 && !m_axis_tlast)
        else $error("error beat with nonzero payload");

    // a new result only follows an accepted input beat
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result beat without an input beat");

    // input back-pressure only while a result is pending
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind bmp24_stream_decoder bmp24_chk u_bmp24_chk (.*);
